FILE: src/assert_macros.svh
// Assertion macros for the 4x4 matrix product block.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, clk, rstn, a, c) \
lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error("lbl");
`define ASSERT_NEXT(lbl, clk, rstn, a, c) \
lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error("lbl");
`endif

FILE: src/mm4_pkg.sv
// Types and constants for the 4x4 matrix product block.
// No dependencies.
package mm4_pkg;
    localparam int DIM = 4;
    localparam int CELLS = 16;
    typedef enum logic [1:0] {ST_LOAD, ST_CALC, ST_SEND} state_t;
endpackage

FILE: src/matrix_multiply_4x4.sv
// 4x4 signed fixed-point matrix product. Loads 32 elements at one per cycle
// while start is held, then per result runs a clear step, 4 MAC steps and a
// done strobe. All 16 results share the single MAC; a new run is taken only
// after the last. busy is high while computing and sending. Reset clears
// control; element cells are not reset. Results cannot be stalled by the receiver.
`include "assert_macros.svh"
module matrix_multiply_4x4
    import mm4_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] element_value,
    output logic               done,
    output logic signed [31:0] product_value,
    output logic [3:0]         product_index,
    output logic               last_element
);
    state_t state_reg, state_next;
    logic [4:0] load_reg, load_next;
    logic [3:0] idx_reg, idx_next;
    logic [2:0] step_reg, step_next;
    logic signed [31:0] chain [0:2*CELLS];
    logic shift, clear, acc_en;
    logic signed [31:0] mac_out;

    assign chain[0] = element_value;
    assign shift = start && !busy;
    genvar g;
    generate
        for (g = 0; g < 2*CELLS; g++)
        begin : g_cell
            mm4_cell u_cell (.clk(clk), .shift(shift), .din(chain[g]),
                             .dout(chain[g+1]));
        end
    endgenerate
    // chain[32] is left[0], chain[17] is left[15]; chain[16] right[0].
    logic [1:0] k;
    logic [3:0] li, ri;
    assign k  = step_reg[1:0];
    assign li = {idx_reg[3:2], k};
    assign ri = {k, idx_reg[1:0]};
    mm4_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (.clk(clk), .clear(clear),
        .acc_en(acc_en), .a(chain[6'(32) - 6'(li)]), .b(chain[6'(16) - 6'(ri)]),
        .result(mac_out));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            load_reg  <= '0;
            idx_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            load_reg  <= load_next;
            idx_reg   <= idx_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        load_next = load_reg;
        idx_next = idx_reg;
        step_next = step_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (start)
                begin
                    load_next = load_reg + 5'd1;
                    if (load_reg == 5'd31)
                    begin
                        state_next = ST_CALC;
                        idx_next = '0;
                        step_next = '0;
                    end
                end
            end
            ST_CALC:
            begin
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd4)
                begin
                    state_next = ST_SEND;
                end
            end
            ST_SEND:
            begin
                step_next = '0;
                idx_next = idx_reg + 4'd1;
                state_next = (idx_reg == 4'd15) ? ST_LOAD : ST_CALC;
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_comb
    begin
        busy = (state_reg != ST_LOAD);
        done = (state_reg == ST_SEND);
        clear = (state_reg == ST_CALC) && (step_reg == 3'd0);
        acc_en = (state_reg == ST_CALC) && (step_reg != 3'd0);
        product_value = mac_out;
        product_index = idx_reg;
        last_element = done && (idx_reg == 4'd15);
    end

    `ASSERT_IMPL(a_no_busy_load, clk, rst_n, busy, load_reg == 5'd0)
    `ASSERT_NEXT(a_last_ends, clk, rst_n, last_element, !busy)
    `ASSERT_NEXT(a_send_once, clk, rst_n, done, !done)
endmodule

FILE: src/mm4_cell.sv
// One shift cell of the element chain: holds one element, passes it on.
// Uses mm4_pkg.
module mm4_cell
    import mm4_pkg::*;
(
    input  logic               clk,
    input  logic               shift,
    input  logic signed [31:0] din,
    output logic signed [31:0] dout
);
    logic signed [31:0] data_reg;
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            data_reg <= din;
        end
    end
    assign dout = data_reg;
endmodule

FILE: src/mm4_mac.sv
// Shared multiply-accumulate with floor shift and saturation.
// Uses mm4_pkg.
module mm4_mac
    import mm4_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               clear,
    input  logic               acc_en,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic signed [31:0] result
);
    logic signed [63:0] prod_reg;
    logic signed [65:0] acc_reg;
    logic signed [65:0] acc_next;
    logic signed [65:0] shifted;
    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
        acc_reg  <= acc_next;
    end
    always_comb
    begin
        acc_next = acc_reg;
        if (clear)
        begin
            acc_next = '0;
        end
        else if (acc_en)
        begin
            acc_next = acc_reg + 66'(prod_reg);
        end
    end
    assign shifted = acc_reg >>> FRAC_BITS;
    always_comb
    begin
        if (shifted > 66'sd2147483647)
        begin
            result = 32'sh7fffffff;
        end
        else if (shifted < -66'sd2147483648)
        begin
            result = 32'sh80000000;
        end
        else
        begin
            result = shifted[31:0];
        end
    end
endmodule
